// File: design/raf_pkg.sv
// Shared constants for the running average filter.
package raf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WIN_W      = 6;
  localparam int WIN_MAX    = 63;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd20;
  localparam logic             REG_WINDOW   = 1'b0;

endpackage

// File: design/raf_queue.sv
// Two-word queue that accepts samples and hands them to the back end.
module raf_queue import raf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                q_valid,
  output logic [SAMPLE_W-1:0] q_sample,
  input  logic                q_pop
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [SAMPLE_W-1:0] buf_r [QUEUE_DEPTH];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                push, pop;

  assign in_stall = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_sample = buf_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_sample;
    end
  end

endmodule

// File: design/raf_div.sv
// Restoring divider that produces one quotient bit per cycle.
module raf_div import raf_pkg::*; #(
  parameter int SUM_W = 21
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [WIN_W-1:0]    divisor,
  output logic                done,
  output logic [SAMPLE_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [WIN_W-1:0] rem_r, rem_nxt;
  logic [WIN_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIN_W:0]   trial;
  logic [WIN_W+1:0] diff;

  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r[SAMPLE_W-1:0];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(SUM_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (diff[WIN_W+1]) begin
        rem_nxt = trial[WIN_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[WIN_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

endmodule

// File: design/raf_back.sv
// Back end: ring store, running sum, fill count, divider control and result register.
module raf_back import raf_pkg::*; #(
  parameter int MAX_WINDOW = 32,
  parameter int SUM_W      = 21
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  logic [WIN_W-1:0]    win,
  input  logic                q_valid,
  input  logic [SAMPLE_W-1:0] q_sample,
  output logic                q_pop,
  output logic                div_start,
  output logic [SUM_W-1:0]    div_dividend,
  output logic [WIN_W-1:0]    div_divisor,
  input  logic                div_done,
  input  logic [SAMPLE_W-1:0] div_quotient,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_average
);

  localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W  = ((ADDR_W > WIN_W) ? ADDR_W : WIN_W) + 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACC  = 5'b00010,
    ST_DST  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_RES  = 5'b10000
  } bk_state_t;

  logic [SAMPLE_W-1:0] store_mem [MAX_WINDOW];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SAMPLE_W-1:0] sample_r;

  bk_state_t           state_r, state_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [ADDR_W-1:0]   slot_r, slot_nxt;
  logic [WIN_W-1:0]    held_r, held_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_average_r;
  logic                res_load;
  logic                wr_en;
  logic                filling;
  logic [SAMPLE_W-1:0] old_val;
  logic [CMP_W-1:0]    slot_inc;

  assign filling  = (held_r < win);
  assign old_val  = filling ? '0 : rd_data_r;
  assign slot_inc = CMP_W'(slot_r) + CMP_W'(1);
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign wr_en    = (state_r == ST_ACC);
  assign res_load = (state_r == ST_RES) && (!out_valid_r || !out_stall);

  assign div_start    = (state_r == ST_DST);
  assign div_dividend = sum_r;
  assign div_divisor  = held_r;
  assign out_valid    = out_valid_r;
  assign out_average  = out_average_r;

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    slot_nxt  = slot_r;
    held_nxt  = held_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(sample_r);
        if (slot_inc >= CMP_W'(win)) begin
          slot_nxt = '0;
        end else begin
          slot_nxt = slot_inc[ADDR_W-1:0];
        end
        if (filling) begin
          held_nxt = held_r + 1'b1;
        end
        state_nxt = ST_DST;
      end
      ST_DST: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (res_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (clear) begin
      sum_nxt  = '0;
      slot_nxt = '0;
      held_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      slot_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sample_r <= q_sample;
    end
    if (res_load) begin
      out_average_r <= div_quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[slot_r] <= sample_r;
    end
    if (q_pop) begin
      rd_data_r <= store_mem[slot_r];
    end
  end

endmodule

// File: design/running_average_filter.sv
// Top level of the running average filter with its configuration port.
//
//   port group        direction  handshake              word
//   in_*              input      in_valid / in_stall    in_sample, 16 bits
//   out_*             output     out_valid / out_stall  out_average, 16 bits
//   psel ... prdata   config     APB write, pready = 1  window_size at byte 0
//
// The back end handles one word at a time: the pop, the accumulate, the divider start,
// the bit-serial divider steps and the result load; it pops the next word only after that.
// A two-word input queue takes new words while the back end works.
// A finished result waits in the output register while out_stall is high.
// Reset and any window_size write clear the sum, slot and fill count.
module running_average_filter import raf_pkg::*; #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SAMPLE_W-1:0]   out_average,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int WIN_CAP = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;
  localparam int SUM_W   = SAMPLE_W + ((WIN_CAP > 1) ? $clog2(WIN_CAP) : 1);

  logic [WIN_W-1:0]    win_r, win_nxt;
  logic [WIN_W-1:0]    win_eff;
  logic                reg_hit;
  logic                cfg_wr;
  logic                q_valid;
  logic [SAMPLE_W-1:0] q_sample;
  logic                q_pop;
  logic                div_start;
  logic [SUM_W-1:0]    div_dividend;
  logic [WIN_W-1:0]    div_divisor;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_quotient;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1] == REG_WINDOW);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? CFG_DATA_W'(win_r) : '0;
  assign win_nxt = cfg_wr ? pwdata[WIN_W-1:0] : win_r;

  always_comb begin
    win_eff = win_r;
    if (win_r == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_r > WIN_W'(WIN_CAP)) begin
      win_eff = WIN_W'(WIN_CAP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_RESET;
    end else begin
      win_r <= win_nxt;
    end
  end

  raf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_valid   (q_valid),
    .q_sample  (q_sample),
    .q_pop     (q_pop)
  );

  raf_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  raf_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear        (cfg_wr),
    .win          (win_eff),
    .q_valid      (q_valid),
    .q_sample     (q_sample),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_average  (out_average)
  );

endmodule

// File: tb/average_checker.sv
`timescale 1ns / 100ps
// Checker for the running average filter: predicts each average and compares it.
module average_checker import raf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [SAMPLE_W-1:0]   out_average,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int MAX_WINDOW = 32;
  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = CFG_ADDR_W'(4 * int'(REG_WINDOW));

  logic [SAMPLE_W-1:0] window_store [MAX_WINDOW];
  logic [20:0]         sum_q;
  logic [4:0]          slot_q;
  logic [WIN_W-1:0]    held_q;
  logic [WIN_W-1:0]    window_q;
  logic [SAMPLE_W-1:0] expected_averages [$];

  function automatic void clear_filter();
    foreach (window_store[i]) window_store[i] = '0;
    sum_q = '0;
    slot_q = '0;
    held_q = '0;
  endfunction

  always @(posedge clk) begin
    int                  span;
    int                  slot;
    logic [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      window_q = WINDOW_RESET;
      clear_filter();
      expected_averages.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR) begin
        window_q = pwdata[WIN_W-1:0];
        clear_filter();
      end
      if (out_valid && !out_stall) begin
        if (expected_averages.size() == 0) begin
          $error("average: result %0d arrived with no word outstanding", out_average);
          fail_count++;
        end else begin
          want = expected_averages.pop_front();
          if (out_average !== want) begin
            $error("average mismatch: expected %0d, actual %0d", want, out_average);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        span = (window_q == 0) ? 1 : (window_q > MAX_WINDOW) ? MAX_WINDOW : int'(window_q);
        slot = (int'(slot_q) >= span) ? 0 : int'(slot_q);
        sum_q = sum_q - window_store[slot] + in_sample;
        window_store[slot] = in_sample;
        slot = (slot + 1 >= span) ? 0 : slot + 1;
        slot_q = slot[4:0];
        if (int'(held_q) < span) held_q = held_q + 1'b1;
        expected_averages.push_back(SAMPLE_W'(sum_q / held_q));
      end
    end
    pending <= expected_averages.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the running average filter testbench: stimulus, stalls and verdict.
module tb_top;
  import raf_pkg::*;

  localparam int REG_SPARE = 1;
  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = CFG_ADDR_W'(4 * int'(REG_WINDOW));
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR  = CFG_ADDR_W'(4 * REG_SPARE);
  localparam int ITEMS_PER_PHASE = 60;
  localparam int SETTLE_CYCLES   = 30;
  localparam int HOLD_CYCLES     = 200;
  localparam int STALL_LIMIT     = 5000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample;
  logic                  out_valid;
  logic                  out_stall;
  logic [SAMPLE_W-1:0]   out_average;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  hold_off;
  int                    fail_count;
  int                    pending;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    quiet_cycles;

  running_average_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_average(out_average),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  average_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_average(out_average),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("running_average_filter test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return SAMPLE_W'($urandom_range(255));
      3: return SAMPLE_W'(16'hFFFF - $urandom_range(255));
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering words and wait until every outstanding average has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_window(input logic [WIN_W-1:0] width);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom();
    write_reg(WINDOW_ADDR, {noise[CFG_DATA_W-1:WIN_W], width});
  endtask

  initial begin
    int phase_windows [11];
    int width;
    phase_windows = '{32, 1, 2, 5, 20, 31, 0, 63, 7, 16, -1};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_off <= 1'b0;
    quiet_cycles <= 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Warm-up at the reset window with extreme words.
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
    drain();
    write_reg(WINDOW_ADDR, 32'd1);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h0000);
    drain();
    // A window of zero behaves as a window of one.
    write_reg(WINDOW_ADDR, 32'd0);
    send_sample(16'h1234);
    send_sample(16'hFFFE);
    drain();
    // Only the low six bits of the write data hold the window size.
    write_reg(WINDOW_ADDR, 32'hFFFF_FFC3);
    send_sample(16'hFFFF);
    send_sample(16'h0003);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    drain();
    // A write to an address without a register leaves the history intact.
    write_reg(SPARE_ADDR, 32'h0000_0005);
    send_sample(16'h0010);
    drain();
    // Sizes beyond the store saturate at the full depth.
    write_reg(WINDOW_ADDR, 32'd63);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    drain();
    // Rewriting the same size still clears the history.
    write_reg(WINDOW_ADDR, 32'd63);
    send_sample(16'h0100);
    send_sample(16'hFF00);
    drain();

    for (int phase = 0; phase < 11; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 15;
        recv_idle_pct = 66;
      end else if (phase < 8) begin
        send_idle_pct = 66;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      width = (phase_windows[phase] < 0) ? $urandom_range(63) : phase_windows[phase];
      set_window(WIN_W'(width));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 1 && n == 10) begin
          fork
            begin
              hold_off <= 1'b1;
              repeat (HOLD_CYCLES) @(posedge clk);
              hold_off <= 1'b0;
            end
          join_none
        end
        if (phase == 5 && n == 30) drain();
        send_sample(pick_sample());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("running_average_filter test passed");
    end else begin
      $display("running_average_filter test failed");
    end
    $finish;
  end

endmodule
